[rtl/cpc_pkg.sv]
package cpc_pkg;

  // Datapath widths: coordinates in Q.14, angles in radians scaled by 2^24
  localparam int unsigned XW   = 34;
  localparam int unsigned ZW   = 28;
  localparam int unsigned FRAC = 14;

  localparam logic signed [ZW-1:0] HALF_PI = 28'sd26353589;
  localparam logic signed [ZW-1:0] PI      = 28'sd52707179;

  // Inverse CORDIC gain in Q32 and the finite-iteration correction seed
  localparam logic [31:0] INVK_INF        = 32'd2608131496;
  localparam logic [31:0] INVK_TWO_THIRDS = 32'd1738754331;

  // 180/pi * 128 in Q16
  localparam logic signed [29:0] DEG128 = 30'sd480631834;

  localparam logic signed [16:0] DIST_MAX = 17'sd46341;
  localparam logic signed [16:0] ANG_MAX  = 17'sd23040;

  typedef enum logic {
    FUNC_TO_POLAR = 1'b0,
    FUNC_TO_RECT  = 1'b1
  } func_e;

  // Work item carried along the rotation chain
  typedef struct packed {
    func_e                func;
    logic                 origin;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cell_t;

  // atan(2^-i) scaled by 2^24, rounded to nearest
  function automatic logic signed [ZW-1:0] micro_angle(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      default: r = (i <= 24) ? (ZW'(1) << (24 - i)) : '0;
    endcase
    return r;
  endfunction

  // Gain compensation tuned to the number of micro-rotations
  function automatic logic [31:0] inv_gain(input int unsigned iters);
    logic [31:0] corr;
    corr = (2 * iters < 32) ? (INVK_TWO_THIRDS >> (2 * iters)) : 32'd0;
    return INVK_INF + corr;
  endfunction

endpackage

[rtl/cpc_pre.sv]
module cpc_pre #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic signed [16:0]  operand_a_i,
  input  logic signed [15:0]  operand_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpc_pkg::cell_t      out_item_o
);

  localparam logic [31:0] InvGain = cpc_pkg::inv_gain(ITERATIONS);

  // Stage A: saturate x, scale the distance by the inverse gain
  logic                  a_v_q;
  logic                  a_ready;
  logic                  b_ready;
  cpc_pkg::func_e        a_func_q;
  logic                  a_origin_q;
  logic signed [15:0]    a_x_q;
  logic signed [15:0]    a_y_q;
  logic signed [48:0]    a_prod_q;
  logic signed [15:0]    x_sat;
  logic signed [48:0]    prod_d;

  always_comb begin
    if (operand_a_i > 17'sd32767) begin
      x_sat = 16'sh7fff;
    end else if (operand_a_i < -17'sd32768) begin
      x_sat = 16'sh8000;
    end else begin
      x_sat = operand_a_i[15:0];
    end
  end

  assign prod_d = 49'(operand_a_i) * 49'($signed({1'b0, InvGain}));

  assign a_ready    = !a_v_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_ready) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_func_q   <= cpc_pkg::func_e'(func_i);
      a_origin_q <= (x_sat == 16'sd0) && (operand_b_i == 16'sd0);
      a_x_q      <= x_sat;
      a_y_q      <= operand_b_i;
      a_prod_q   <= prod_d;
    end
  end

  // Stage B: bring the start vector into the convergence range
  logic                            b_v_q;
  cpc_pkg::cell_t                  b_q;
  cpc_pkg::cell_t                  b_d;
  logic signed [cpc_pkg::XW-1:0]   px;
  logic signed [cpc_pkg::XW-1:0]   py;
  logic signed [cpc_pkg::XW-1:0]   rx;
  logic signed [cpc_pkg::ZW-1:0]   rz;

  always_comb begin
    px = cpc_pkg::XW'(a_x_q) <<< cpc_pkg::FRAC;
    py = cpc_pkg::XW'(a_y_q) <<< cpc_pkg::FRAC;
    rx = cpc_pkg::XW'(a_prod_q >>> 18);
    rz = cpc_pkg::ZW'(a_y_q) <<< 11;
    b_d.func   = a_func_q;
    b_d.origin = a_origin_q;
    case (a_func_q)
      cpc_pkg::FUNC_TO_POLAR: begin
        // turn the left half plane by 90 degrees
        if (px < 0) begin
          if (py >= 0) begin
            b_d.x = py;
            b_d.y = -px;
            b_d.z = cpc_pkg::HALF_PI;
          end else begin
            b_d.x = -py;
            b_d.y = px;
            b_d.z = -cpc_pkg::HALF_PI;
          end
        end else begin
          b_d.x = px;
          b_d.y = py;
          b_d.z = '0;
        end
      end
      cpc_pkg::FUNC_TO_RECT: begin
        // fold angles beyond a quarter turn back by pi
        b_d.y = '0;
        if (rz > cpc_pkg::HALF_PI) begin
          b_d.x = -rx;
          b_d.z = rz - cpc_pkg::PI;
        end else if (rz < -cpc_pkg::HALF_PI) begin
          b_d.x = -rx;
          b_d.z = rz + cpc_pkg::PI;
        end else begin
          b_d.x = rx;
          b_d.z = rz;
        end
      end
      default: begin
        b_d.x = rx;
        b_d.y = '0;
        b_d.z = rz;
      end
    endcase
  end

  assign b_ready = !b_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_ready) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_v_q && b_ready) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_v_q;
  assign out_item_o  = b_q;

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> a_v_q)
    else $error("accepted request did not reach the first stage");

endmodule

[rtl/cpc_cell.sv]
module cpc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cpc_pkg::cell_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cpc_pkg::cell_t  out_item_o
);

  localparam logic signed [cpc_pkg::ZW-1:0] Ang = cpc_pkg::micro_angle(IDX);

  logic                            v_q;
  cpc_pkg::cell_t                  q;
  cpc_pkg::cell_t                  d;
  logic signed [cpc_pkg::XW-1:0]   x;
  logic signed [cpc_pkg::XW-1:0]   y;
  logic signed [cpc_pkg::ZW-1:0]   z;
  logic signed [cpc_pkg::XW-1:0]   dx;
  logic signed [cpc_pkg::XW-1:0]   dy;

  assign x  = in_item_i.x;
  assign y  = in_item_i.y;
  assign z  = in_item_i.z;
  assign dx = y >>> IDX;
  assign dy = x >>> IDX;

  // One micro-rotation: drive y to zero or z to zero
  always_comb begin
    d.func   = in_item_i.func;
    d.origin = in_item_i.origin;
    case (in_item_i.func)
      cpc_pkg::FUNC_TO_POLAR: begin
        if (y >= 0) begin
          d.x = x + dx;
          d.y = y - dy;
          d.z = z + Ang;
        end else begin
          d.x = x - dx;
          d.y = y + dy;
          d.z = z - Ang;
        end
      end
      cpc_pkg::FUNC_TO_RECT: begin
        if (z >= 0) begin
          d.x = x - dx;
          d.y = y + dy;
          d.z = z - Ang;
        end else begin
          d.x = x + dx;
          d.y = y - dy;
          d.z = z + Ang;
        end
      end
      default: begin
        d.x = x;
        d.y = y;
        d.z = z;
      end
    endcase
  end

  // Advance when the next cell can take the request
  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      q <= d;
    end
  end

  assign out_valid_o = v_q;
  assign out_item_o  = q;

endmodule

[rtl/cpc_post.sv]
module cpc_post #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cpc_pkg::cell_t     in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] result_a_o,
  output logic signed [16:0] result_b_o
);

  localparam logic [31:0] InvGain = cpc_pkg::inv_gain(ITERATIONS);

  // Round a Q.14 coordinate and clamp it to 17 bits
  function automatic logic signed [16:0] round_sat(input logic signed [cpc_pkg::XW-1:0] v);
    logic signed [cpc_pkg::XW-1:0] r;
    logic signed [16:0]            s;
    r = (v + cpc_pkg::XW'(1 << (cpc_pkg::FRAC - 1))) >>> cpc_pkg::FRAC;
    if (r > cpc_pkg::XW'(65535)) begin
      s = 17'sd65535;
    end else if (r < -cpc_pkg::XW'(65536)) begin
      s = -17'sd65536;
    end else begin
      s = r[16:0];
    end
    return s;
  endfunction

  // Stage C: gain and degree multiplies, rectangular rounding
  logic                   c_v_q;
  logic                   c_ready;
  logic                   d_ready;
  cpc_pkg::func_e         c_func_q;
  logic                   c_origin_q;
  logic [63:0]            c_dist_q;
  logic signed [57:0]     c_ang_q;
  logic signed [16:0]     c_rx_q;
  logic signed [16:0]     c_ry_q;
  logic [31:0]            xu;
  logic signed [cpc_pkg::ZW-1:0] zi;

  assign xu = in_item_i.x[31:0];
  assign zi = in_item_i.z;

  assign c_ready    = !c_v_q || d_ready;
  assign in_ready_o = c_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (c_ready) begin
      c_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && c_ready) begin
      c_func_q   <= in_item_i.func;
      c_origin_q <= in_item_i.origin;
      c_dist_q   <= 64'(xu) * 64'(InvGain);
      c_ang_q    <= 58'(zi) * 58'(cpc_pkg::DEG128);
      c_rx_q     <= round_sat(in_item_i.x);
      c_ry_q     <= round_sat(in_item_i.y);
    end
  end

  // Stage D: round, clamp and select the result
  logic               d_v_q;
  cpc_pkg::func_e     d_func_q;
  logic signed [16:0] res_a_q;
  logic signed [16:0] res_b_q;
  logic signed [16:0] res_a_d;
  logic signed [16:0] res_b_d;
  logic [63:0]        dist_sum;
  logic [17:0]        dist_r;
  logic signed [57:0] ang_sum;
  logic signed [17:0] ang_r;

  always_comb begin
    dist_sum = c_dist_q + (64'd1 << 45);
    dist_r   = dist_sum[63:46];
    ang_sum  = c_ang_q + (58'sd1 <<< 39);
    ang_r    = ang_sum[57:40];
    case (c_func_q)
      cpc_pkg::FUNC_TO_POLAR: begin
        if (c_origin_q) begin
          res_a_d = '0;
          res_b_d = '0;
        end else begin
          res_a_d = (dist_r > 18'(cpc_pkg::DIST_MAX)) ? cpc_pkg::DIST_MAX : dist_r[16:0];
          if (ang_r > 18'(cpc_pkg::ANG_MAX)) begin
            res_b_d = cpc_pkg::ANG_MAX;
          end else if (ang_r < -18'(cpc_pkg::ANG_MAX)) begin
            res_b_d = -cpc_pkg::ANG_MAX;
          end else begin
            res_b_d = ang_r[16:0];
          end
        end
      end
      cpc_pkg::FUNC_TO_RECT: begin
        res_a_d = c_rx_q;
        res_b_d = c_ry_q;
      end
      default: begin
        res_a_d = c_rx_q;
        res_b_d = c_ry_q;
      end
    endcase
  end

  assign d_ready = !d_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (d_ready) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_v_q && d_ready) begin
      d_func_q <= c_func_q;
      res_a_q  <= res_a_d;
      res_b_q  <= res_b_d;
    end
  end

  assign out_valid_o = d_v_q;
  assign result_a_o  = res_a_q;
  assign result_b_o  = res_b_q;

  dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v_q && d_func_q == cpc_pkg::FUNC_TO_POLAR |->
      res_a_q >= 17'sd0 && res_a_q <= cpc_pkg::DIST_MAX)
    else $error("polar distance out of range");

  ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v_q && d_func_q == cpc_pkg::FUNC_TO_POLAR |->
      res_b_q >= -cpc_pkg::ANG_MAX && res_b_q <= cpc_pkg::ANG_MAX)
    else $error("polar angle out of range");

endmodule

[rtl/cartesian_polar_converter_unit.sv]
// Pipeline: two setup stages, one CORDIC cell per micro-rotation and two rounding
//   stages lie between an accepted request and its result.
// Throughput: one request per cycle while out_stall_i is low; every stage holds
//   one request and passes it on whenever the stage after it is empty or moving.
// Reset: rst_ni clears all stage valid bits asynchronously; no other state.
module cartesian_polar_converter_unit #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic signed [16:0] operand_a_i,
  input  logic signed [15:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] result_a_o,
  output logic signed [16:0] result_b_o
);

  cpc_pkg::cell_t            chain_item [0:ITERATIONS];
  logic [ITERATIONS:0]       chain_valid;
  logic [ITERATIONS:0]       chain_ready;
  logic                      pre_ready;

  assign in_stall_o = !pre_ready;

  // Setup: saturation, gain scaling, quadrant fold
  cpc_pre #(
    .ITERATIONS(ITERATIONS)
  ) u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (pre_ready),
    .func_i      (func_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_item_o  (chain_item[0])
  );

  // Row of micro-rotation cells
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    cpc_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_item_i   (chain_item[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_item_o  (chain_item[k+1])
    );
  end

  // Gain compensation, degree scaling, rounding and output register
  cpc_post #(
    .ITERATIONS(ITERATIONS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[ITERATIONS]),
    .in_ready_o  (chain_ready[ITERATIONS]),
    .in_item_i   (chain_item[ITERATIONS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .result_a_o  (result_a_o),
    .result_b_o  (result_b_o)
  );

  full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result side was free");

endmodule
